// ----- src/mcds_pkg.sv -----
package mcds_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int SAMPLE_W      = 16;
   localparam int PIX_W         = 3 * SAMPLE_W;
   localparam int FW_W          = 13;
   localparam int FH_W          = 14;
   localparam int ROW_W         = 14;
   localparam int IROW_W        = ROW_W + 1;   // input row may run past the height while flushing
   localparam int CSR_DATA_W    = 14;
   localparam int QUEUE_DEPTH   = 4;
   localparam int DIFF_W        = SAMPLE_W + 1;

   localparam logic [FW_W-1:0]     FRAME_WIDTH_RST  = FW_W'(4096);
   localparam logic [FH_W-1:0]     FRAME_HEIGHT_RST = FH_W'(3072);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX       = 16'hFFFF;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // r in the low bits, matching the stream data layout
   typedef struct packed {
      sample_type b;
      sample_type g;
      sample_type r;
   } pixel_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_FLUSH = 1'b1
   } mode_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic restart;
      logic emit;
      logic smooth;
      logic frame_end;
   } cmd_flags_type;

   typedef logic [8:0][DIFF_W-1:0] diff_set_type;

   // rank-based median: element with at most four smaller and at least four
   // others smaller-or-equal
   function automatic logic [DIFF_W-1:0] median9(input diff_set_type v);
      logic [3:0]        lt;
      logic [3:0]        le;
      logic [DIFF_W-1:0] m;
      logic              found;
      m     = '0;
      found = 1'b0;
      for (int i = 0; i < 9; i++) begin
         lt = '0;
         le = '0;
         for (int j = 0; j < 9; j++) begin
            if (j != i) begin
               if ($signed(v[j]) < $signed(v[i]))  lt = lt + 4'd1;
               if ($signed(v[j]) <= $signed(v[i])) le = le + 4'd1;
            end
         end
         if (!found && lt <= 4'd4 && le >= 4'd4) begin
            m     = v[i];
            found = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic sample_type add_clamp(input logic [DIFF_W-1:0] med, input sample_type g);
      logic signed [DIFF_W:0] s;
      s = $signed({med[DIFF_W-1], med}) + $signed({2'b00, g});
      if (s < 0) return '0;
      else if (s > $signed({2'b00, SAMPLE_MAX})) return SAMPLE_MAX;
      else return s[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- src/mcds_queue.sv -----
module mcds_queue
   import mcds_pkg::*;
#(
   parameter int DEPTH  = QUEUE_DEPTH,
   parameter int DATA_W = PIX_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("queue empty after a push");

endmodule

// ----- src/mcds_front.sv -----
module mcds_front
   import mcds_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output cmd_flags_type         cmd_flags,
   output pixel_type             cmd_pix,
   output logic [COL_W-1:0]      cmd_ic,
   output logic [COL_W-1:0]      cmd_ocol
);

   localparam int WW = COL_W + 1;

   logic [FW_W-1:0]   frame_width_ff;
   logic [FH_W-1:0]   frame_height_ff;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;

   logic [WW-1:0]     eff_w, wm1;
   logic [ROW_W-1:0]  eff_h;
   logic              accept, is_flush, rst_frame, ignore, emit;
   logic [IROW_W-1:0] ir;
   logic [COL_W-1:0]  ic0, ic, oc;
   logic [ROW_W-1:0]  orow;
   logic [WW-1:0]     ic_inc, oc_inc;

   always_comb begin
      if (frame_width_ff == '0) eff_w = WW'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
      else eff_w = WW'(frame_width_ff);
      wm1   = eff_w - 1'b1;
      eff_h = (frame_height_ff == '0) ? ROW_W'(1) : frame_height_ff;
   end

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign is_flush   = (req_tuser == MODE_FLUSH);

   always_comb begin
      rst_frame = !is_flush && (in_row_ff >= {1'b0, eff_h});
      ignore    = is_flush && ((in_row_ff < {1'b0, eff_h}) || (out_row_ff >= eff_h));
      ir   = rst_frame ? '0 : in_row_ff;
      ic0  = rst_frame ? '0 : in_col_ff;
      oc   = rst_frame ? '0 : out_col_ff;
      orow = rst_frame ? '0 : out_row_ff;
      ic   = ({1'b0, ic0} >= eff_w) ? wm1[COL_W-1:0] : ic0;
      emit = ((ir >= IROW_W'(2)) || (ir == IROW_W'(1) && ic != '0)) && (orow < eff_h);

      cmd_flags.restart   = rst_frame;
      cmd_flags.emit      = emit;
      cmd_flags.smooth    = (orow >= ROW_W'(2)) && (({1'b0, orow} + 2'd2) < {1'b0, eff_h})
                            && (oc >= COL_W'(2)) && (({2'b00, oc} + 2'd2) < {1'b0, eff_w});
      cmd_flags.frame_end = (orow == eff_h - 1'b1) && ({1'b0, oc} == wm1);
      cmd_pix  = is_flush ? '0 : pixel_type'(req_tdata);
      cmd_ic   = ic;
      cmd_ocol = oc;
      cmd_push = accept && !ignore;

      ic_inc = {1'b0, ic} + 1'b1;
      oc_inc = {1'b0, oc} + 1'b1;
      if (ic_inc >= eff_w) begin
         in_col_in = '0;
         in_row_in = ir + 1'b1;
      end else begin
         in_col_in = ic_inc[COL_W-1:0];
         in_row_in = ir;
      end
      out_col_in = oc;
      out_row_in = orow;
      if (emit) begin
         if (oc_inc >= eff_w) begin
            out_col_in = '0;
            out_row_in = orow + 1'b1;
         end else begin
            out_col_in = oc_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wr_data[FH_W-1:0];
            default:          frame_width_ff  <= frame_width_ff;
         endcase
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd_push) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ----- src/mcds_back.sv -----
module mcds_back
   import mcds_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int COL_W     = $clog2(MAX_WIDTH),
   parameter int DEPTH     = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   win_clear,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  cmd_flags_type          cmd_flags,
   input  pixel_type              cmd_pix,
   input  logic [COL_W-1:0]       cmd_ic,
   input  logic [COL_W-1:0]       cmd_ocol,
   input  logic [$clog2(DEPTH):0] res_count,
   output logic                   res_push,
   output logic [PIX_W:0]         res_data
);

   localparam int CNT_W = $clog2(DEPTH) + 1;

   pixel_type        upper_line_mem  [MAX_WIDTH];
   pixel_type        middle_line_mem [MAX_WIDTH];
   pixel_type        upper_rd_ff, middle_rd_ff;

   logic             s1_valid_ff;
   cmd_flags_type    s1_flags_ff;
   pixel_type        s1_pix_ff;
   logic [COL_W-1:0] s1_ocol_ff;

   pixel_type        win_ff [3][3];
   pixel_type        win_in [3][3];
   pixel_type        sh     [3][3];
   pixel_type        out_pix;
   diff_set_type     d_red, d_blue;
   logic             s1_emit;

   assign s1_emit = s1_valid_ff && s1_flags_ff.emit;
   // credit: the result queue must hold everything already in flight
   assign cmd_pop = cmd_valid
                    && (({1'b0, res_count} + (CNT_W+1)'(s1_emit)) < (CNT_W+1)'(DEPTH));

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            sh[c][r] = '0;
         end
      end
      if (!s1_flags_ff.restart) begin
         for (int r = 0; r < 3; r++) begin
            sh[0][r] = win_ff[1][r];
            sh[1][r] = win_ff[2][r];
         end
      end
      sh[2][0] = upper_rd_ff;
      sh[2][1] = middle_rd_ff;
      sh[2][2] = s1_pix_ff;

      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            d_red[c*3+r]  = {1'b0, sh[c][r].r} - {1'b0, sh[c][r].g};
            d_blue[c*3+r] = {1'b0, sh[c][r].b} - {1'b0, sh[c][r].g};
         end
      end

      out_pix = sh[1][1];
      if (s1_flags_ff.smooth) begin
         out_pix.r = add_clamp(median9(d_red), sh[1][1].g);
         out_pix.b = add_clamp(median9(d_blue), sh[1][1].g);
      end

      win_in = win_ff;
      if (s1_valid_ff) begin
         win_in = sh;
         if (s1_flags_ff.emit) win_in[1][1] = out_pix;
      end
      if (win_clear) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_in[c][r] = '0;
            end
         end
      end
   end

   assign res_push = s1_emit;
   assign res_data = {s1_flags_ff.frame_end, out_pix};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else begin
         s1_valid_ff <= cmd_pop;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_flags_ff <= cmd_flags;
         s1_pix_ff   <= cmd_pix;
         s1_ocol_ff  <= cmd_ocol;
      end
   end

   // read-first: the column read returns the pixel stored one row earlier
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         middle_rd_ff            <= middle_line_mem[cmd_ic];
         middle_line_mem[cmd_ic] <= cmd_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) upper_rd_ff <= upper_line_mem[cmd_ic];
      if (s1_emit) upper_line_mem[s1_ocol_ff] <= out_pix;
   end

endmodule

// ----- src/median_color_difference_smoother_core.sv -----
// Median color-difference smoother, 3x3 window, 16-bit RGB raster stream.
// req_*: one pixel per transfer, raster order; req_tuser set marks a flush
//   item that drains one pending output once the whole frame has arrived.
// rsp_*: one pixel per transfer; rsp_tlast on the last pixel of the frame.
// csr_*: frame_width (index 0) and frame_height (index 1); a write restarts
//   the frame. Write only while the block is idle.
// Interior pixels (two or more from every edge) get red and blue replaced by
//   the median of the nine channel-minus-green differences plus center green,
//   clamped to 0..65535. Green and border pixels pass unchanged.
// Throughput: one pixel per clock while rsp_tready keeps up, set by the
//   median feedback of the smoothed center into the next window.
// A result leaves frame_width+1 pixels behind its input; an accepted
//   transfer passes the command queue, stage 1 and the result queue.
// Reset clears positions, window and queues and restores width 4096 and
//   height 3072; line stores hold stale data, only read for border windows.
// A stalled rsp_tready fills the 4-entry result queue, then the command
//   queue, after which req_tready drops; nothing is lost.
module median_color_difference_smoother_core
   import mcds_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // red_in, green_in, blue_in
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // red_out, green_out, blue_out
   output logic                  rsp_tlast,   // frame_end
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int FLAGS_W = $bits(cmd_flags_type);
   localparam int CMD_W   = FLAGS_W + PIX_W + 2 * COL_W;
   localparam int RES_W   = PIX_W + 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH) + 1;

   // front -> command queue
   logic             f_push;
   cmd_flags_type    f_flags;
   pixel_type        f_pix;
   logic [COL_W-1:0] f_ic, f_ocol;
   logic             cq_full, cq_empty, cq_pop;
   logic [CMD_W-1:0] cq_head;
   logic [CNT_W-1:0] cq_count;

   // back -> result queue
   logic             b_push;
   logic [RES_W-1:0] b_data;
   logic             rq_full, rq_empty, rq_pop;
   logic [RES_W-1:0] rq_head;
   logic [CNT_W-1:0] rq_count;

   mcds_front #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd_full    (cq_full),
      .cmd_push    (f_push),
      .cmd_flags   (f_flags),
      .cmd_pix     (f_pix),
      .cmd_ic      (f_ic),
      .cmd_ocol    (f_ocol)
   );

   mcds_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(CMD_W)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_flags, f_pix, f_ic, f_ocol}),
      .pop       (cq_pop),
      .pop_data  (cq_head),
      .full      (cq_full),
      .empty     (cq_empty),
      .count     (cq_count)
   );

   mcds_back #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W), .DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .win_clear (csr_wr_en),
      .cmd_valid (!cq_empty),
      .cmd_pop   (cq_pop),
      .cmd_flags (cmd_flags_type'(cq_head[CMD_W-1 -: FLAGS_W])),
      .cmd_pix   (pixel_type'(cq_head[2*COL_W +: PIX_W])),
      .cmd_ic    (cq_head[COL_W +: COL_W]),
      .cmd_ocol  (cq_head[COL_W-1:0]),
      .res_count (rq_count),
      .res_push  (b_push),
      .res_data  (b_data)
   );

   mcds_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(RES_W)) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (b_push),
      .push_data (b_data),
      .pop       (rq_pop),
      .pop_data  (rq_head),
      .full      (rq_full),
      .empty     (rq_empty),
      .count     (rq_count)
   );

   // result queue head is the output register
   assign rsp_tvalid = !rq_empty;
   assign rsp_tdata  = rq_head[PIX_W-1:0];
   assign rsp_tlast  = rq_head[PIX_W];
   assign rq_pop     = rsp_tvalid && rsp_tready;

   a_cmd_count_bound: assert property (@(posedge clock) disable iff (reset)
      cq_count <= CNT_W'(QUEUE_DEPTH))
      else $error("command queue count out of range");
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      b_push |-> (!rq_full || rq_pop))
      else $error("result arrives with no room in result queue");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

// ----- dv/tb_median_color_difference_smoother_core.sv -----
module tb_median_color_difference_smoother_core;
   import mcds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW        = MAX_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_WAIT  = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;   // red_in, green_in, blue_in
   logic                  req_tuser;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIX_W-1:0]      rsp_tdata;   // red_out, green_out, blue_out
   logic                  rsp_tlast;   // frame_end
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   median_color_difference_smoother_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   typedef struct packed {
      logic      last;
      pixel_type px;
   } out_pixel_type;

   // one stimulus row; has_exp marks rows whose result is typed in directly
   typedef struct {
      mode_type      mode;
      pixel_type     px;
      logic          has_exp;
      out_pixel_type exp_px;
   } stim_row_type;

   // shadow of the block: line stores, window, positions, registers
   pixel_type     upper_line[MAXW];
   pixel_type     middle_line[MAXW];
   pixel_type     win[3][3];   // [left, center, right][up, mid, low]
   int unsigned   in_col, in_row, out_col, out_row;
   int unsigned   cfg_width, cfg_height;

   out_pixel_type expected_pixels[$];
   stim_row_type  directed_rows[$];
   int            error_count;
   int            cycle_count;
   int            result_count;
   int            hold_off;      // long receiver stall, counted down in cycles
   logic          no_idle;       // stretch with no idling on either side

   always #5 clock = ~clock;

   function automatic int unsigned width_eff();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAXW) return MAXW;
      return cfg_width;
   endfunction

   function automatic int unsigned height_eff();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      foreach (win[c, r]) win[c][r] = '0;
   endfunction

   // median of the nine channel-minus-green differences plus center green
   function automatic sample_type smoothed_sample(bit blue);
      int d[9];
      int k, t, res;
      k = 0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            d[k] = int'(blue ? win[c][r].b : win[c][r].r) - int'(win[c][r].g);
            k++;
         end
      end
      for (int i = 0; i < 9; i++) begin
         for (int j = i + 1; j < 9; j++) begin
            if (d[j] < d[i]) begin
               t    = d[i];
               d[i] = d[j];
               d[j] = t;
            end
         end
      end
      res = d[4] + int'(win[1][1].g);
      if (res < 0) res = 0;
      if (res > 65535) res = 65535;
      return sample_type'(res);
   endfunction

   // shift the window by one column and produce the pixel it may emit
   function automatic bit shift_window(pixel_type p, output out_pixel_type o);
      int unsigned w, h, ic;
      bit          fire;
      w  = width_eff();
      h  = height_eff();
      ic = (in_col >= w) ? w - 1 : in_col;
      fire = (in_row >= 2 || (in_row == 1 && ic >= 1)) && out_row < h;
      for (int r = 0; r < 3; r++) begin
         win[0][r] = win[1][r];
         win[1][r] = win[2][r];
      end
      win[2][0] = upper_line[ic];
      win[2][1] = middle_line[ic];
      win[2][2] = p;
      middle_line[ic] = p;
      o = '0;
      if (fire) begin
         o.px = win[1][1];
         if (out_row >= 2 && out_row + 2 < h && out_col >= 2 && out_col + 2 < w) begin
            o.px.r = smoothed_sample(1'b0);
            o.px.b = smoothed_sample(1'b1);
         end
         win[1][1] = o.px;
         if (out_col < MAXW) upper_line[out_col] = o.px;
         o.last = (out_row == h - 1 && out_col == w - 1);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      ic++;
      if (ic >= w) begin
         ic = 0;
         in_row++;
      end
      in_col = ic;
      return fire;
   endfunction

   function automatic bit predict_pixel(mode_type mode, pixel_type p, output out_pixel_type o);
      int unsigned h;
      h = height_eff();
      o = '0;
      if (mode == MODE_FLUSH) begin
         if (in_row < h || out_row >= h) return 1'b0;
         return shift_window('0, o);
      end
      if (in_row >= h) restart_frame();
      return shift_window(p, o);
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      case ($urandom_range(0, 5))
         0: p = '0;
         1: p = '1;
         2: begin
            p.g = sample_type'($urandom);
            p.r = p.g;
            p.b = p.g;
         end
         default: p = {sample_type'($urandom), sample_type'($urandom), sample_type'($urandom)};
      endcase
      return p;
   endfunction

   function automatic bit take_gap();
      return !no_idle && ($urandom_range(0, 99) < 27);
   endfunction

   // csr write: only called while nothing is in flight
   task automatic write_reg(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == REG_FRAME_WIDTH) cfg_width = value & 16'h1FFF;
      else cfg_height = value & 16'h3FFF;
      restart_frame();
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
   endtask

   task automatic wait_idle();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one transfer on the request side; predicts at acceptance
   task automatic send_item(mode_type mode, pixel_type p, logic has_exp = 1'b0,
                            out_pixel_type exp_px = '0);
      out_pixel_type o;
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_pixel(mode, p, o)) begin
         if (has_exp && o !== exp_px) begin
            $display("%0t: table entry disagrees with prediction: %h vs %h",
                     $time, exp_px, o);
            error_count++;
         end
         expected_pixels.push_back(has_exp ? exp_px : o);
      end
      @(negedge clock);
   endtask

   // whole frame, mostly well formed, then flushes to drain
   task automatic send_frame(int unsigned w, int unsigned h, bit broken);
      int unsigned n;
      n = w * h;
      if (broken) n = $urandom_range(1, n);
      for (int unsigned i = 0; i < n; i++) begin
         if (broken && $urandom_range(0, 9) == 0) send_item(MODE_FLUSH, rand_pixel());
         else send_item(MODE_PIXEL, rand_pixel());
      end
      for (int unsigned i = 0; i < w + 1 + (broken ? 2 : 0); i++)
         send_item(MODE_FLUSH, rand_pixel());
      req_tvalid <= 1'b0;
   endtask

   // response side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_gap();
      end
   end

   // check each transfer against the oldest prediction
   always @(posedge clock) begin
      out_pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.px   = rsp_tdata;
         got.last = rsp_tlast;
         result_count++;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.px.r !== want.px.r || got.px.g !== want.px.g ||
                got.px.b !== want.px.b || got.last !== want.last) begin
               $display("%0t: mismatch expected r=%h g=%h b=%h last=%b actual r=%h g=%h b=%h last=%b",
                        $time, want.px.r, want.px.g, want.px.b, want.last,
                        got.px.r, got.px.g, got.px.b, got.last);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_pixels.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      stim_row_type  row;
      out_pixel_type e;
      int unsigned   items;
      int unsigned   w, h;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = MODE_PIXEL;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_wr_data = '0;
      rsp_tready = 1'b0;
      hold_off = 0;
      no_idle = 1'b0;
      error_count = 0;
      cycle_count = 0;
      result_count = 0;
      cfg_width = 4096;
      cfg_height = 3072;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      restart_frame();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: width 1 height 2, extremes pass straight through
      set_frame(1, 2);
      row = '{MODE_FLUSH, '0, 1'b0, '0};          // flush before frame: ignored
      directed_rows.push_back(row);
      row = '{MODE_PIXEL, '1, 1'b0, '0};
      directed_rows.push_back(row);
      row = '{MODE_PIXEL, '0, 1'b0, '0};
      directed_rows.push_back(row);
      e.px = '1; e.last = 1'b0;
      row = '{MODE_FLUSH, '0, 1'b1, e};
      directed_rows.push_back(row);
      e.px = '0; e.last = 1'b1;
      row = '{MODE_FLUSH, '1, 1'b1, e};
      directed_rows.push_back(row);
      row = '{MODE_FLUSH, '1, 1'b0, '0};          // nothing pending: ignored
      directed_rows.push_back(row);
      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].px,
                   directed_rows[i].has_exp, directed_rows[i].exp_px);
      req_tvalid <= 1'b0;
      wait_idle();

      // 5x5 frame: one smoothed center, with clamping extremes around it
      set_frame(5, 5);
      for (int i = 0; i < 25; i++) begin
         pixel_type p;
         p.r = (i % 2) ? 16'hFFFF : 16'h0000;
         p.g = (i % 3) ? 16'h0000 : 16'hFFFF;
         p.b = (i % 2) ? 16'h0000 : 16'hFFFF;
         send_item(MODE_PIXEL, p);
      end
      // new frame started on top of pending outputs, then drained
      for (int i = 0; i < 25; i++) send_item(MODE_PIXEL, rand_pixel());
      for (int i = 0; i < 8; i++) send_item(MODE_FLUSH, rand_pixel());
      req_tvalid <= 1'b0;
      wait_idle();

      // width 0 and height 0 act as 1
      set_frame(0, 0);
      send_frame(1, 1, 1'b0);
      wait_idle();

      // width above the maximum acts as 4096: a partial first row, no output yet
      set_frame(8191, 2);
      for (int i = 0; i < 100; i++) send_item(MODE_PIXEL, rand_pixel());
      req_tvalid <= 1'b0;
      wait_idle();

      // long receiver stall while the sender keeps offering
      set_frame(6, 5);
      hold_off = 300;
      send_frame(6, 5, 1'b0);
      wait_idle();

      // random frames
      items = 0;
      while (items < 1300) begin
         if ($urandom_range(0, 5) == 0) begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
         end else begin
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 9);
         end
         if (items > 400 && items < 700) no_idle = 1'b1;
         else no_idle = 1'b0;
         set_frame(w, h);
         send_frame(w, h, $urandom_range(0, 7) == 0);
         items += w * h + w + 1;
         wait_idle();
      end
      write_reg(REG_FRAME_HEIGHT, 16383);
      wait_idle();

      $display("covered %0d results over frames from 1x1 up to 12 wide, plus clamped widths,",
               result_count);
      $display("with flush drains, broken frames, clamps and a long output stall");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
